// ===== design/hse_pkg.sv =====
// shared types and constants of the heap sort engine
// no dependencies; used by hse_cell and heap_sort_engine_unit
`default_nettype none

package hse_pkg;

	// data width of one element
	localparam int DATA_W = 32;

	// default number of cells in the chain
	localparam int DEPTH_DEF = 64;

	// one element handed from cell to cell
	typedef struct packed {
		logic              vld;
		logic [DATA_W-1:0] data;
	} slot_t;

endpackage

`default_nettype wire

// ===== design/heap_sort_engine_unit.sv =====
// top level of the heap sort engine: load control, chain of sorting cells,
// output stream; depends on hse_pkg and hse_cell
`default_nettype none

// Sorts a set of signed 32-bit values in ascending order. Items are taken
// one per cycle while loading; each enters a chain of DEPTH cells and is
// placed by compare-and-pass as it ripples down the chain. The item with
// tlast closes the set; the block then lets the last insertion settle down
// the chain, and emits the set from the head of the chain, one item per
// accepted output cycle, with tlast on the greatest value. Values beyond
// DEPTH are dropped and tuser is set on every result of that set. The settle
// time is set by the length of the chain. No input is taken while settling
// or emitting.
module heap_sort_engine_unit #(
	parameter int DEPTH = hse_pkg::DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] value
	input  wire logic        s_axis_tlast,   // last_item
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [31:0] sorted_value
	output logic             m_axis_tlast,   // last_result
	output logic             m_axis_tuser    // [0] overflow
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_DRAIN = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] drain_q;
	logic             ovf_q;

	logic             in_acc;
	logic             out_acc;
	logic             full;

	hse_pkg::slot_t   ins  [DEPTH+1];
	hse_pkg::slot_t   cur  [DEPTH+1];

	assign full          = (count_q == CNT_W'(DEPTH));
	assign s_axis_tready = (state_q == ST_LOAD);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_acc       = m_axis_tvalid && m_axis_tready;

	// new item enters the head of the chain unless the store is full
	assign ins[0].vld  = in_acc && !full;
	assign ins[0].data = s_axis_tdata;

	// empty slot behind the tail
	assign cur[DEPTH].vld  = 1'b0;
	assign cur[DEPTH].data = '0;

	// chain of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		hse_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (out_acc),
			.ins_in   (ins[i]),
			.ins_out  (ins[i+1]),
			.nxt_in   (cur[i+1]),
			.cur_out  (cur[i])
		);
	end

	// sequencer: load, settle, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			drain_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
						if (s_axis_tlast) begin
							state_q <= ST_DRAIN;
							drain_q <= CNT_W'(DEPTH);
						end
					end
				end
				ST_DRAIN: begin
					if (drain_q == '0) begin
						state_q <= ST_EMIT;
					end else begin
						drain_q <= drain_q - CNT_W'(1);
					end
				end
				ST_EMIT: begin
					if (out_acc && m_axis_tlast) begin
						state_q <= ST_LOAD;
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// head of the chain is the output
	assign m_axis_tvalid = (state_q == ST_EMIT) && cur[0].vld;
	assign m_axis_tdata  = cur[0].data;
	assign m_axis_tlast  = !cur[1].vld;
	assign m_axis_tuser  = ovf_q;

	// item count stays within the chain
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("item count beyond chain depth");

	// results leave in ascending order
	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && !m_axis_tlast) |=>
			(m_axis_tvalid && ($signed(m_axis_tdata) >= $signed($past(m_axis_tdata)))))
		else $error("results out of order");

	// after the final result the block loads again with a clean count
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && m_axis_tlast) |=> (s_axis_tready && count_q == '0 && !ovf_q))
		else $error("block not rearmed after set");

endmodule

`default_nettype wire

// ===== design/hse_cell.sv =====
// one cell of the sorting chain: holds one element, keeps the smaller of held and arriving
// values, passes the larger one on, takes the next cell's element on a shift; depends on hse_pkg
`default_nettype none

module hse_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           shift_en,
	input  wire hse_pkg::slot_t ins_in,
	output hse_pkg::slot_t      ins_out,
	input  wire hse_pkg::slot_t nxt_in,
	output hse_pkg::slot_t      cur_out
);

	logic                       vld_q;
	logic [hse_pkg::DATA_W-1:0] data_q;
	logic                       pass_vld_q;
	logic [hse_pkg::DATA_W-1:0] pass_data_q;

	logic                       vld_d;
	logic [hse_pkg::DATA_W-1:0] data_d;
	hse_pkg::slot_t             pass_d;

	// insert or shift decision
	always_comb begin
		vld_d       = vld_q;
		data_d      = data_q;
		pass_d.vld  = 1'b0;
		pass_d.data = ins_in.data;
		if (shift_en) begin
			vld_d  = nxt_in.vld;
			data_d = nxt_in.data;
		end else if (ins_in.vld) begin
			if (!vld_q) begin
				vld_d  = 1'b1;
				data_d = ins_in.data;
			end else if ($signed(ins_in.data) < $signed(data_q)) begin
				data_d      = ins_in.data;
				pass_d.vld  = 1'b1;
				pass_d.data = data_q;
			end else begin
				pass_d.vld  = 1'b1;
				pass_d.data = ins_in.data;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= 1'b0;
			pass_vld_q <= 1'b0;
		end else begin
			vld_q      <= vld_d;
			pass_vld_q <= pass_d.vld;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		data_q      <= data_d;
		pass_data_q <= pass_d.data;
	end

	assign ins_out.vld  = pass_vld_q;
	assign ins_out.data = pass_data_q;
	assign cur_out.vld  = vld_q;
	assign cur_out.data = data_q;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for heap_sort_engine_unit: sets of signed values go in on
// s_axis, each sorted run is checked field by field on m_axis; uses hse_pkg
module tb_top;

	localparam int SET_MAX   = hse_pkg::DEPTH_DEF;
	localparam int TAIL_WAIT = 2 * SET_MAX + 16;

	typedef enum int {PICK_WIDE, PICK_NARROW, PICK_EDGE} pick_t;

	typedef struct {
		logic [hse_pkg::DATA_W-1:0] value;
		logic                       last;
		logic                       drain;   // hold this item back until all results are out
	} load_item_t;

	typedef struct {
		logic [hse_pkg::DATA_W-1:0] value;
		logic                       last;
		logic                       ovf;
	} sorted_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [31:0]       s_axis_tdata;   // [31:0] value
	logic              s_axis_tlast;   // last_item
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [31:0]       m_axis_tdata;   // [31:0] sorted_value
	logic              m_axis_tlast;   // last_result
	logic              m_axis_tuser;   // [0] overflow

	load_item_t        load_queue [$];
	sorted_t           sorted_due [$];
	load_item_t        next_item;
	sorted_t           want;
	logic signed [31:0] element_held [SET_MAX];
	int                held_count  = 0;
	logic              set_dropped = 1'b0;
	logic              in_fire     = 1'b0;
	int                n_queued    = 0;
	int                n_taken     = 0;
	int                mismatches  = 0;
	int                send_idle;
	int                recv_idle;

	heap_sort_engine_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// store one value; on the closing value sort the held set and queue the run
	task automatic predict_sort(input logic [31:0] v, input logic last);
		logic signed [31:0] run [SET_MAX];
		logic signed [31:0] key;
		int                 j;
		sorted_t            r;
		if (held_count < SET_MAX) begin
			element_held[held_count] = v;
			held_count++;
		end else begin
			set_dropped = 1'b1;
		end
		if (last) begin
			// insertion sort, signed order
			for (int i = 0; i < held_count; i++) begin
				key = element_held[i];
				j = i;
				while (j > 0 && run[j-1] > key) begin
					run[j] = run[j-1];
					j--;
				end
				run[j] = key;
			end
			for (int i = 0; i < held_count; i++) begin
				r.value = run[i];
				r.last  = (i == held_count - 1);
				r.ovf   = set_dropped;
				sorted_due.push_back(r);
			end
			held_count  = 0;
			set_dropped = 1'b0;
		end
	endtask

	task automatic add_item(input logic [31:0] v, input logic last, input logic drain);
		load_item_t it;
		it.value = v;
		it.last  = last;
		it.drain = drain;
		load_queue.push_back(it);
		n_queued++;
	endtask

	function automatic logic [31:0] pick_value(input pick_t pick);
		logic [31:0] v;
		case (pick)
			PICK_WIDE: begin
				v = $urandom;
			end
			PICK_NARROW: begin
				// small spread around zero, lots of duplicates
				v = 32'($urandom_range(8)) - 32'd4;
			end
			default: begin
				if ($urandom_range(1) == 0)
					v = 32'h8000_0000 + 32'($urandom_range(2));
				else
					v = 32'h7FFF_FFFF - 32'($urandom_range(2));
			end
		endcase
		return v;
	endfunction

	task automatic add_set(input int n, input pick_t pick, input logic drain);
		for (int i = 0; i < n; i++)
			add_item(pick_value(pick), i == n - 1, drain && i == 0);
	endtask

	task automatic add_random_sets(input int budget);
		int used;
		int n;
		used = 0;
		while (used < budget) begin
			n = $urandom_range(10, 1);
			add_set(n, pick_t'($urandom_range(2)), $urandom_range(5) == 0);
			used += n;
		end
	endtask

	// wait until every queued item is taken and every run has come out
	task automatic finish_phase();
		while (n_taken != n_queued || sorted_due.size() != 0)
			@(posedge clk);
	endtask

	// input driver and output ready, changed on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && !in_fire) begin
				// offered item not yet taken, keep it on the bus
			end else if (load_queue.size() != 0
					&& !(load_queue[0].drain && sorted_due.size() != 0)
					&& $urandom_range(99) >= send_idle) begin
				next_item = load_queue.pop_front();
				s_axis_tdata  <= next_item.value;
				s_axis_tlast  <= next_item.last;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// monitor: check results, then feed accepted items to the predictor
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (sorted_due.size() == 0) begin
					$error("sorted_value: expected no item, got %0d", $signed(m_axis_tdata));
					mismatches++;
				end else begin
					want = sorted_due.pop_front();
					if (m_axis_tdata !== want.value) begin
						$error("sorted_value: expected %0d, got %0d",
							$signed(want.value), $signed(m_axis_tdata));
						mismatches++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("last_result: expected %0b, got %0b", want.last, m_axis_tlast);
						mismatches++;
					end
					if (m_axis_tuser !== want.ovf) begin
						$error("overflow: expected %0b, got %0b", want.ovf, m_axis_tuser);
						mismatches++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				predict_sort(s_axis_tdata, s_axis_tlast);
				n_taken++;
			end
			in_fire <= s_axis_tvalid && s_axis_tready;
		end
	end

	// stimulus and verdict
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		send_idle     = 14;
		recv_idle     = 61;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// extremes and duplicated extremes in one set
		add_item(32'h8000_0000, 1'b0, 1'b0);
		add_item(32'h7FFF_FFFF, 1'b0, 1'b0);
		add_item(32'h0000_0000, 1'b0, 1'b0);
		add_item(32'hFFFF_FFFF, 1'b0, 1'b0);
		add_item(32'h0000_0001, 1'b0, 1'b0);
		add_item(32'h7FFF_FFFF, 1'b0, 1'b0);
		add_item(32'h8000_0000, 1'b1, 1'b0);
		// single value set, held until the first run is out
		add_item(32'd5, 1'b1, 1'b1);
		// two values in reverse order
		add_item(32'd100, 1'b0, 1'b0);
		add_item(-32'sd100, 1'b1, 1'b0);
		// all equal
		for (int i = 0; i < 3; i++)
			add_item(-32'sd7, i == 2, i == 0);
		// already ascending, then descending
		for (int i = 1; i <= 5; i++)
			add_item(32'(i), i == 5, 1'b0);
		for (int i = 5; i >= 1; i--)
			add_item(32'(i), i == 1, 1'b0);
		add_random_sets(2);
		// a set that fills the store exactly
		add_set(SET_MAX, PICK_EDGE, 1'b1);
		finish_phase();

		send_idle = 61;
		recv_idle = 14;
		add_random_sets(2);
		// store full: two values dropped, the closing one among them
		add_set(SET_MAX + 2, PICK_WIDE, 1'b1);
		add_random_sets(1);
		finish_phase();

		send_idle = 0;
		recv_idle = 0;
		add_random_sets(3);
		finish_phase();

		repeat (TAIL_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog
	initial begin
		#400_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== heap_sort_engine_unit.f =====
design/hse_pkg.sv
design/hse_cell.sv
design/heap_sort_engine_unit.sv
sim/tb_top.sv
